### src/mexp_pkg.sv
// Shared widths, constants and handshake types for the modular exponentiation core.
package mexp_pkg;

   localparam int MOD_W     = 31;                      // modulus and residue width
   localparam int BASE_W    = 63;                      // base operand width
   localparam int EXP_W     = 63;                      // exponent field width
   localparam int EXP_BITS  = 63;                      // exponent bits scanned
   localparam int OPA_W     = BASE_W;                  // multiplier serial operand width
   localparam int CNT_W     = $clog2(OPA_W + 1);       // multiplier bit counter width
   localparam int REQ_W     = ((BASE_W + EXP_W + 7) / 8) * 8;
   localparam int RSP_W     = ((MOD_W + 7) / 8) * 8;

   localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);

   // Request to the serial multiplier: launch pulse and operand length.
   typedef struct packed {
      logic start;
      logic long_op;   // serial operand is the full base width, else residue width
   } mul_req_type;

endpackage

### src/modular_exponentiation_core.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
// Each request item carries a base and an exponent; the core returns one
// response item, base ^ exponent mod modulus, with the modulus taken from
// the configuration register (reset value 1000000007, written through
// csr_wr_en / csr_wr_data; the user must write it only while the core is idle,
// which the core itself does not enforce). All arithmetic runs on one
// bit-serial modular multiplier. The base is first reduced by running it
// through the multiplier against 1 mod m, over all 63 base bits. Each
// exponent bit, from the least significant up to the highest set one, then
// costs a multiply (set bits only) and a squaring, each over the 31 residue
// bits, with a decision step between bits. A zero modulus skips the
// multiplier and answers zero. The finished result waits for the output
// register to free. One item is in work at a time; the response sits in an
// output register, so the next request is taken while the previous response
// still waits for rsp_tready.
module modular_exponentiation_core
   import mexp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,    // [62:0] base_value, [125:63] exponent, rest zero
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,    // [30:0] power_result, [31] zero
   // configuration
   input  logic             csr_wr_en,
   input  logic [MOD_W-1:0] csr_wr_data   // modulus
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_NEXT   = 3'd2;
   localparam logic [2:0] ST_MULT   = 3'd3;
   localparam logic [2:0] ST_SQUARE = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam int PAD_W = OPA_W - MOD_W;

   logic [2:0]          state_ff, state_in;
   logic [MOD_W-1:0]    modulus_ff;
   logic [MOD_W-1:0]    acc_ff, acc_in;
   logic [MOD_W-1:0]    sq_ff, sq_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]    rsp_data_ff, rsp_data_in;

   mul_req_type         mul_req;
   logic [OPA_W-1:0]    mul_a;
   logic [MOD_W-1:0]    mul_b;
   logic                mul_done;
   logic [MOD_W-1:0]    mul_result;

   logic                req_fire;
   logic [MOD_W-1:0]    one_mod;
   logic [BASE_W-1:0]   req_base;
   logic [EXP_W-1:0]    req_exp;

   assign req_base   = req_tdata[BASE_W-1:0];
   assign req_exp    = req_tdata[BASE_W+EXP_W-1:BASE_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // 1 mod m: zero for a modulus of one
   assign one_mod    = (modulus_ff == MOD_W'(1)) ? '0 : MOD_W'(1);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;
      mul_a        = {sq_ff, {PAD_W{1'b0}}};
      mul_b        = sq_ff;

      // drop the response once the sink takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               exp_in = req_exp[EXP_BITS-1:0];
               if (modulus_ff == '0) begin
                  // no reduction possible: answer zero
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  // reduce the base: base * (1 mod m) mod m
                  acc_in          = one_mod;
                  mul_req.start   = 1'b1;
                  mul_req.long_op = 1'b1;
                  mul_a           = OPA_W'(req_base);
                  mul_b           = one_mod;
                  state_in        = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               sq_in    = mul_result;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // stop as soon as no set exponent bit remains
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               mul_req.start = 1'b1;
               mul_a         = {acc_ff, {PAD_W{1'b0}}};
               mul_b         = sq_ff;
               state_in      = ST_MULT;
            end else begin
               mul_req.start = 1'b1;
               state_in      = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in        = mul_result;
               mul_req.start = 1'b1;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               sq_in    = mul_result;
               exp_in   = exp_ff >> 1;
               state_in = ST_NEXT;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
      end
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   mexp_modmul u_modmul (
      .clock      (clock),
      .reset      (reset),
      .mul_req    (mul_req),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .modulus    (modulus_ff),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule

### src/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: one bit of the serial operand per cycle.
module mexp_modmul
   import mexp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mul_req_type       mul_req,
   input  logic [OPA_W-1:0]  mul_a,       // serial operand, MSB first, left aligned
   input  logic [MOD_W-1:0]  mul_b,       // parallel operand, below the modulus
   input  logic [MOD_W-1:0]  modulus,
   output logic              mul_done,
   output logic [MOD_W-1:0]  mul_result
);

   logic [OPA_W-1:0] a_ff, a_in;
   logic [MOD_W-1:0] b_ff, b_in;
   logic [MOD_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [MOD_W:0] m_ext;
   logic [MOD_W:0] dbl;
   logic [MOD_W:0] dbl_red;
   logic [MOD_W:0] sum;
   logic [MOD_W:0] sum_red;

   // One step: r = (2r + bit * b) mod m, with two conditional subtracts.
   always_comb begin
      m_ext   = {1'b0, modulus};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
      sum     = dbl_red + (a_ff[OPA_W-1] ? {1'b0, b_ff} : '0);
      sum_red = (sum >= m_ext) ? sum - m_ext : sum;
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         a_in     = mul_a;
         b_in     = mul_b;
         r_in     = '0;
         count_in = mul_req.long_op ? CNT_W'(OPA_W) : CNT_W'(MOD_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         r_in     = sum_red[MOD_W-1:0];
         a_in     = {a_ff[OPA_W-2:0], 1'b0};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign mul_done   = done_ff;
   assign mul_result = r_ff;

endmodule
